// ===== rtl/core/cbd_pkg.sv =====
package cbd_pkg;

    // Default width of the chunk-size counter
    localparam int CBD_SIZE_BITS   = 32;
    // Default depth of the queue between front and back (power of two)
    localparam int CBD_QUEUE_DEPTH = 4;

    // Characters of the framing
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HTAB  = 8'h09;

    // One input request
    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_of_message;
        logic       last_of_input;
    } cbd_in_t;

    // One result request
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       complete;
        logic       failed;
    } cbd_out_t;

    // A byte after classification by the front
    typedef struct packed {
        logic [7:0] in_byte;
        logic       first;
        logic       last;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
        logic       is_blank;
    } cbd_class_t;

endpackage

// ===== rtl/core/chunked_body_decoder.sv =====
// Chunked transfer body decoder.
// Input channel (byte_valid / byte_stall / byte_data) takes one body byte per
// request, with first_of_message marking a new message and last_of_input the
// final available byte. Output channel (result_valid / result_stall /
// result_data) gives at most one result per byte: a payload byte, the
// completion flag on the LF of the terminating zero chunk, or an error flag.
// Bytes that cause no result (size lines, CR LF) are consumed silently.
// Throughput: one byte per cycle unless result_stall holds the output, set by
// the chunk sequencer in the back part. Each byte passes the classify
// register, the queue and the output register before its result is valid.
// A stalled result holds in the output register; the queue between the
// classifier and the sequencer keeps taking bytes until it fills, and only
// then byte_stall rises.
// Reset clears the queue, empties both channels and puts the parser in the
// awaiting-chunk-size phase; no clearing pass is needed.
module chunked_body_decoder
    import cbd_pkg::*;
#(
    parameter int SIZE_BITS   = CBD_SIZE_BITS,
    parameter int QUEUE_DEPTH = CBD_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_stall,
    input  cbd_in_t  byte_data,
    output logic     result_valid,
    input  logic     result_stall,
    output cbd_out_t result_data
);

    logic       cls_valid;
    logic       cls_stall;
    cbd_class_t cls_data;
    logic       q_valid;
    logic       q_take;
    cbd_class_t q_data;

    // Byte classifier
    cbd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .cls_valid  (cls_valid),
        .cls_stall  (cls_stall),
        .cls_data   (cls_data)
    );

    // Decoupling queue
    cbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cls_valid),
        .push_stall (cls_stall),
        .push_data  (cls_data),
        .pop_valid  (q_valid),
        .pop_take   (q_take),
        .pop_data   (q_data)
    );

    // Chunk sequencer and result register
    cbd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_take       (q_take),
        .q_data       (q_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

// ===== rtl/core/cbd_front.sv =====
module cbd_front
    import cbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  cbd_in_t    byte_data,
    output logic       cls_valid,
    input  logic       cls_stall,
    output cbd_class_t cls_data
);

    logic       valid_reg;
    logic       valid_next;
    cbd_class_t cls_reg;
    cbd_class_t cls_next;
    logic       take;
    logic [7:0] c;

    // Stage is free when empty or when its entry moves on this cycle
    assign byte_stall = valid_reg && cls_stall;
    assign take       = byte_valid && !byte_stall;
    assign c          = byte_data.in_byte;

    // Classify the incoming byte
    always_comb
    begin
        cls_next          = cls_reg;
        valid_next        = valid_reg;
        if (!cls_stall)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next            = 1'b1;
            cls_next.in_byte      = c;
            cls_next.first        = byte_data.first_of_message;
            cls_next.last         = byte_data.last_of_input;
            cls_next.is_cr        = (c == CH_CR);
            cls_next.is_lf        = (c == CH_LF);
            cls_next.is_blank     = (c == CH_SP) || (c == CH_HTAB);
            cls_next.is_hex       = 1'b0;
            cls_next.hex_val      = 4'h0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                cls_next.is_hex  = 1'b1;
                cls_next.hex_val = c[3:0];
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                cls_next.is_hex  = 1'b1;
                cls_next.hex_val = 4'(c - 8'h57);
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                cls_next.is_hex  = 1'b1;
                cls_next.hex_val = 4'(c - 8'h37);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg <= cls_next;
    end

    assign cls_valid = valid_reg;
    assign cls_data  = cls_reg;

endmodule

// ===== rtl/core/cbd_queue.sv =====
module cbd_queue
    import cbd_pkg::*;
#(
    parameter int DEPTH = CBD_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_stall,
    input  cbd_class_t push_data,
    output logic       pop_valid,
    input  logic       pop_take,
    output cbd_class_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cbd_class_t             mem [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   push;
    logic                   pop;

    assign push_stall = (count_reg == CNT_W'(DEPTH));
    assign push       = push_valid && !push_stall;
    assign pop_valid  = (count_reg != '0);
    assign pop        = pop_take && pop_valid;
    assign pop_data   = mem[rd_ptr_reg];

    // Pointers wrap at the power-of-two depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/cbd_back.sv =====
module cbd_back
    import cbd_pkg::*;
#(
    parameter int SIZE_BITS = CBD_SIZE_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    output logic       q_take,
    input  cbd_class_t q_data,
    output logic       result_valid,
    input  logic       result_stall,
    output cbd_out_t   result_data
);

    typedef enum logic [3:0] {
        PH_SIZE     = 4'd0,
        PH_EXT      = 4'd1,
        PH_SIZE_LF  = 4'd2,
        PH_DATA     = 4'd3,
        PH_DATA_CR  = 4'd4,
        PH_DATA_LF  = 4'd5,
        PH_FINAL_CR = 4'd6,
        PH_FINAL_LF = 4'd7,
        PH_DONE     = 4'd8,
        PH_ERROR    = 4'd9
    } phase_t;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [SIZE_BITS-1:0]   remain_reg;
    logic [SIZE_BITS-1:0]   remain_next;
    logic                   digit_reg;
    logic                   digit_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    cbd_out_t               out_reg;
    cbd_out_t               out_next;

    phase_t                 ph;
    logic [SIZE_BITS-1:0]   rem;
    logic [SIZE_BITS-1:0]   rem_dec;
    logic                   dig;
    logic                   has;
    logic                   done;
    logic                   fail;
    logic                   pop;

    // Back runs whenever the output register has room
    assign pop     = q_valid && (!out_valid_reg || !result_stall);
    assign q_take  = pop;
    assign rem_dec = rem - 1'b1;

    // Message start clears state ahead of this byte
    always_comb
    begin
        ph  = q_data.first ? PH_SIZE : phase_reg;
        rem = q_data.first ? '0 : remain_reg;
        dig = q_data.first ? 1'b0 : digit_reg;
    end

    // Chunk sequencer
    always_comb
    begin
        phase_next     = phase_reg;
        remain_next    = remain_reg;
        digit_next     = digit_reg;
        has            = 1'b0;
        done           = 1'b0;
        fail           = 1'b0;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            phase_next  = ph;
            remain_next = rem;
            digit_next  = dig;
            unique case (ph)
                PH_SIZE:
                begin
                    if (q_data.is_hex)
                    begin
                        // Top nibble set means one more digit overflows
                        if (|rem[SIZE_BITS-1 -: 4])
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            remain_next = {rem[SIZE_BITS-5:0], q_data.hex_val};
                            digit_next  = 1'b1;
                        end
                    end
                    else if (!dig)
                    begin
                        if (!q_data.is_blank)
                        begin
                            fail = 1'b1;
                        end
                    end
                    else if (q_data.is_cr)
                    begin
                        phase_next = PH_SIZE_LF;
                    end
                    else
                    begin
                        phase_next = PH_EXT;
                    end
                end
                PH_EXT:
                begin
                    if (q_data.is_cr)
                    begin
                        phase_next = PH_SIZE_LF;
                    end
                end
                PH_SIZE_LF:
                begin
                    if (!q_data.is_lf)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        phase_next = (rem == '0) ? PH_FINAL_CR : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    has         = 1'b1;
                    remain_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next = PH_DATA_CR;
                    end
                end
                PH_DATA_CR:
                begin
                    if (!q_data.is_cr)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA_LF;
                    end
                end
                PH_DATA_LF:
                begin
                    if (!q_data.is_lf)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        phase_next  = PH_SIZE;
                        remain_next = '0;
                        digit_next  = 1'b0;
                    end
                end
                PH_FINAL_CR:
                begin
                    if (!q_data.is_cr)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_FINAL_LF;
                    end
                end
                PH_FINAL_LF:
                begin
                    if (!q_data.is_lf)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                        done       = 1'b1;
                    end
                end
                PH_DONE, PH_ERROR:
                begin
                end
                default:
                begin
                    fail = 1'b1;
                end
            endcase
            if (fail)
            begin
                phase_next = PH_ERROR;
            end
            // Input ended before the message finished
            if (q_data.last && phase_next != PH_DONE && phase_next != PH_ERROR)
            begin
                fail       = 1'b1;
                phase_next = PH_ERROR;
            end
            out_valid_next    = has || done || fail;
            out_next.out_byte = has ? q_data.in_byte : 8'h00;
            out_next.has_byte = has;
            out_next.complete = done;
            out_next.failed   = fail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIZE;
            remain_reg    <= '0;
            digit_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            remain_reg    <= remain_next;
            digit_reg     <= digit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    // A delivered result always carries at least one flag
    a_result_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.has_byte || out_reg.complete || out_reg.failed))
        else $error("result without any flag");

    // Payload and completion never come from the same byte
    a_byte_not_complete: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.has_byte && out_reg.complete))
        else $error("payload byte marked complete");

    // A byte taken in the data phase yields a payload result
    a_data_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !q_data.first && phase_reg == PH_DATA) |=>
            (out_valid_reg && out_reg.has_byte))
        else $error("data byte not passed through");

    // Error phase is left only by a message start
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERROR && !(pop && q_data.first)) |=> (phase_reg == PH_ERROR))
        else $error("error phase left without message start");

endmodule

// ===== verif/tb_chunked_body_decoder.sv =====
`timescale 1ns / 1ps

module tb_chunked_body_decoder;
    import cbd_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_BYTES = 2000;
    // three-stage pipe plus queue depth, with margin
    localparam int DRAIN_CYCLES = 12;
    localparam logic [CBD_SIZE_BITS-1:0] SIZE_ALL_ONES = '1;

    typedef enum logic [3:0] {
        SZ_DIGITS,
        SZ_EXT,
        SZ_LF,
        BODY,
        BODY_CR,
        BODY_LF,
        TAIL_CR,
        TAIL_LF,
        MSG_DONE,
        MSG_ERROR
    } parse_phase_e;

    // Tracks the decoder state and holds the results each request should produce
    class chunk_decode_model;
        parse_phase_e             phase;
        logic [CBD_SIZE_BITS-1:0] remaining;
        logic                     digit_seen;
        cbd_out_t                 expected_results[$];
        int                       mismatches;

        function new();
            restart();
            mismatches = 0;
        endfunction

        function void restart();
            phase      = SZ_DIGITS;
            remaining  = '0;
            digit_seen = 1'b0;
        endfunction

        function void note_byte(cbd_in_t req);
            logic [7:0] c;
            logic       is_hex;
            logic [3:0] hv;
            logic       has;
            logic       done;
            logic       fail;
            cbd_out_t   res;
            c    = req.in_byte;
            has  = 1'b0;
            done = 1'b0;
            fail = 1'b0;
            if (req.first_of_message)
                restart();

            // hex digit value; letters map via low nibble + 9
            is_hex = 1'b1;
            hv     = 4'h0;
            if (c >= "0" && c <= "9")
                hv = c[3:0];
            else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
                hv = c[3:0] + 4'd9;
            else
                is_hex = 1'b0;

            case (phase)
                SZ_DIGITS:
                begin
                    if (is_hex)
                    begin
                        if (remaining > (SIZE_ALL_ONES >> 4))
                            fail = 1'b1;
                        else
                        begin
                            remaining  = (remaining << 4) | hv;
                            digit_seen = 1'b1;
                        end
                    end
                    else if (!digit_seen)
                    begin
                        if (c != CH_SP && c != CH_HTAB)
                            fail = 1'b1;
                    end
                    else if (c == CH_CR)
                        phase = SZ_LF;
                    else
                        phase = SZ_EXT;
                end
                SZ_EXT:
                begin
                    if (c == CH_CR)
                        phase = SZ_LF;
                end
                SZ_LF:
                begin
                    if (c != CH_LF)
                        fail = 1'b1;
                    else
                        phase = (remaining == 0) ? TAIL_CR : BODY;
                end
                BODY:
                begin
                    has       = 1'b1;
                    remaining = remaining - 1'b1;
                    if (remaining == 0)
                        phase = BODY_CR;
                end
                BODY_CR:
                begin
                    if (c != CH_CR)
                        fail = 1'b1;
                    else
                        phase = BODY_LF;
                end
                BODY_LF:
                begin
                    if (c != CH_LF)
                        fail = 1'b1;
                    else
                        restart();
                end
                TAIL_CR:
                begin
                    if (c != CH_CR)
                        fail = 1'b1;
                    else
                        phase = TAIL_LF;
                end
                TAIL_LF:
                begin
                    if (c != CH_LF)
                        fail = 1'b1;
                    else
                    begin
                        phase = MSG_DONE;
                        done  = 1'b1;
                    end
                end
                MSG_DONE, MSG_ERROR:
                begin
                end
                default:
                    fail = 1'b1;
            endcase

            if (fail)
                phase = MSG_ERROR;
            // input ran out before the message finished
            if (req.last_of_input && phase != MSG_DONE && phase != MSG_ERROR)
            begin
                fail  = 1'b1;
                phase = MSG_ERROR;
            end

            if (has || done || fail)
            begin
                res.out_byte = has ? c : 8'h00;
                res.has_byte = has;
                res.complete = done;
                res.failed   = fail;
                expected_results.push_back(res);
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(cbd_out_t got);
            cbd_out_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual byte=%h has=%b done=%b err=%b",
                         $time, got.out_byte, got.has_byte, got.complete, got.failed);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("has_byte", 8'(want.has_byte), 8'(got.has_byte));
            compare_field("complete", 8'(want.complete), 8'(got.complete));
            compare_field("failed",   8'(want.failed),   8'(got.failed));
        endfunction
    endclass

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     byte_valid   = 1'b0;
    logic     byte_stall;
    cbd_in_t  byte_data    = '0;
    logic     result_valid;
    logic     result_stall = 1'b0;
    cbd_out_t result_data;

    chunk_decode_model decoder_model = new();

    // body text of the message under construction, then the planned requests
    logic [7:0] msg_text[$];
    cbd_in_t    byte_plan[$];
    int         cycle_count = 0;

    // receiver stall pattern state
    int   stall_mode  = 0;
    int   mode_left   = 0;
    int   run_left    = 0;
    logic stall_level = 1'b0;

    chunked_body_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always #10 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver stall: free-flowing, random, or long on/off runs
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(40, 200);
        end
        mode_left--;
        case (stall_mode)
            0:
                stall_level = 1'b0;
            1:
                stall_level = ($urandom_range(0, 99) < 30);
            default:
            begin
                if (run_left == 0)
                begin
                    stall_level = ~stall_level;
                    run_left    = $urandom_range(1, 12);
                end
                run_left--;
            end
        endcase
        result_stall <= stall_level;
    end

    // Result checking
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            decoder_model.check_result(result_data);
    end

    function automatic logic [7:0] random_case(logic [7:0] c);
        // lower-case letter to upper-case half the time
        if (c >= "a" && c <= "f" && $urandom_range(0, 1))
            return c - 8'h20;
        return c;
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            msg_text.push_back(s[i]);
    endtask

    task automatic add_crlf();
        msg_text.push_back(CH_CR);
        msg_text.push_back(CH_LF);
    endtask

    task automatic add_hex(int unsigned n, int lead_zeros);
        string s;
        s = $sformatf("%0h", n);
        repeat (lead_zeros)
            msg_text.push_back("0");
        for (int i = 0; i < s.len(); i++)
            msg_text.push_back(random_case(s[i]));
    endtask

    // Extension: starts with a non-hex byte, runs up to CR
    task automatic add_extension();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0:       b = CH_SP;
            1:       b = CH_HTAB;
            2:       b = ";";
            default:
            begin
                b = CH_CR;
                while (b == CH_CR || (b >= "0" && b <= "9") || (b >= "a" && b <= "f")
                       || (b >= "A" && b <= "F"))
                    b = 8'($urandom_range(0, 255));
            end
        endcase
        msg_text.push_back(b);
        repeat ($urandom_range(0, 3))
        begin
            b = CH_CR;
            while (b == CH_CR)
                b = 8'($urandom_range(0, 255));
            msg_text.push_back(b);
        end
    endtask

    task automatic add_size_line(int unsigned n);
        repeat ($urandom_range(0, 2))
            msg_text.push_back($urandom_range(0, 1) ? CH_SP : CH_HTAB);
        add_hex(n, $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
        if ($urandom_range(0, 3) == 0)
            add_extension();
        add_crlf();
    endtask

    function automatic int unsigned pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 8);
        if (r < 97)
            return $urandom_range(9, 40);
        return $urandom_range(100, 300);
    endfunction

    // Well-formed body: data chunks, then the zero chunk and its CR LF
    task automatic add_message_body();
        int unsigned n;
        repeat ($urandom_range(0, 4))
        begin
            n = pick_size();
            add_size_line(n);
            repeat (n)
                msg_text.push_back(8'($urandom_range(0, 255)));
            add_crlf();
        end
        add_size_line(0);
        add_crlf();
    endtask

    // Turn the message text into requests: new-message flag on the first byte
    task automatic commit_message(bit end_flag);
        cbd_in_t req;
        for (int i = 0; i < msg_text.size(); i++)
        begin
            req.in_byte          = msg_text[i];
            req.first_of_message = (i == 0);
            req.last_of_input    = end_flag && (i == msg_text.size() - 1);
            byte_plan.push_back(req);
        end
        msg_text.delete();
    endtask

    task automatic add_random_message();
        int      kind;
        int      start;
        int      pos;
        int      cut;
        cbd_in_t junk;
        kind  = $urandom_range(0, 99);
        start = byte_plan.size();
        if (kind >= 90 && kind < 95)
        begin
            // size line with too many significant digits
            repeat ($urandom_range(0, 1))
                msg_text.push_back(CH_SP);
            add_hex($urandom_range(1, 15), 0);
            repeat ($urandom_range(8, 10))
                add_hex($urandom_range(0, 15), 0);
            add_crlf();
        end
        else
            add_message_body();

        // one corrupted byte anywhere
        if (kind >= 70 && kind < 82)
        begin
            pos = $urandom_range(0, msg_text.size() - 1);
            msg_text[pos] = 8'($urandom_range(0, 255));
        end
        // truncated message, end of input on the new final byte
        if (kind >= 82 && kind < 90)
        begin
            cut = $urandom_range(1, msg_text.size());
            while (msg_text.size() > cut)
                void'(msg_text.pop_back());
        end
        commit_message((kind >= 82 && kind < 90) || $urandom_range(0, 2) == 0);

        // restart in the middle of a message
        if (kind >= 95 && byte_plan.size() - start > 1)
            byte_plan[$urandom_range(start + 1, byte_plan.size() - 1)].first_of_message = 1'b1;

        // stray bytes after the message, ignored until the next start
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                junk.in_byte          = 8'($urandom_range(0, 255));
                junk.first_of_message = 1'b0;
                junk.last_of_input    = 1'($urandom_range(0, 1));
                byte_plan.push_back(junk);
            end
        end
    endtask

    task automatic queue_directed();
        cbd_in_t stray;
        // blanks, extension with a blank, zero data byte, completion, then a stray byte
        add_text(" \t1 x");
        add_crlf();
        msg_text.push_back(8'h00);
        add_crlf();
        add_text("0");
        add_crlf();
        add_crlf();
        commit_message(1'b1);
        stray.in_byte          = "Z";
        stray.first_of_message = 1'b0;
        stray.last_of_input    = 1'b0;
        byte_plan.push_back(stray);
        // missing digit, then a byte ignored in the error phase
        add_text("g");
        commit_message(1'b0);
        byte_plan.push_back(stray);
        // largest legal size, then one digit more overflows
        add_text("0FFFFFFFF0");
        commit_message(1'b0);
        // input ends on a payload byte
        add_text("1");
        add_crlf();
        msg_text.push_back(8'hFF);
        commit_message(1'b1);
        // CR on the size line not followed by LF
        add_text("1");
        msg_text.push_back(CH_CR);
        add_text("X");
        commit_message(1'b0);
    endtask

    // Sender: bursts of random length separated by random gaps
    task automatic send_planned_bytes();
        int burst_left;
        int gap_left;
        burst_left = $urandom_range(1, 30);
        gap_left   = 0;
        while (byte_plan.size() > 0)
        begin
            @(negedge clk);
            if (gap_left > 0)
            begin
                byte_valid <= 1'b0;
                gap_left--;
            end
            else
            begin
                byte_valid <= 1'b1;
                byte_data  <= byte_plan[0];
            end
            @(posedge clk);
            if (byte_valid && !byte_stall)
            begin
                decoder_model.note_byte(byte_data);
                void'(byte_plan.pop_front());
                burst_left--;
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        burst_left = $urandom_range(80, 200);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = $urandom_range(0, 8);
                    end
                end
            end
        end
        @(negedge clk);
        byte_valid <= 1'b0;
    endtask

    // Wait for every expected result, then let silent requests leave the pipe
    task automatic wait_drained();
        while (decoder_model.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_directed();
        send_planned_bytes();
        wait_drained();

        // random traffic in two halves with a full drain in between
        for (int half = 0; half < 2; half++)
        begin
            while (byte_plan.size() < RANDOM_BYTES / 2)
                add_random_message();
            send_planned_bytes();
            wait_drained();
        end

        if (decoder_model.mismatches == 0 && decoder_model.expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cbd_pkg.sv
rtl/core/cbd_front.sv
rtl/core/cbd_queue.sv
rtl/core/cbd_back.sv
rtl/core/chunked_body_decoder.sv
verif/tb_chunked_body_decoder.sv
